// ===== rtl/top_k_degree_selector_unit_assert.svh =====
// Assertion macros for the top-k degree selector.
// Included by the top level; needs no other file.
`ifndef TOP_K_DEGREE_SELECTOR_UNIT_ASSERT_SVH
`define TOP_K_DEGREE_SELECTOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define TKDS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define TKDS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TKDS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define TKDS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/tkds_pkg.sv =====
// Shared types and constants of the top-k degree selector.
// No dependencies; used by every module of the block.
package tkds_pkg;

   localparam int HOT_W = 11;
   localparam logic [HOT_W-1:0] HOT_COUNT_RESET = 11'd16;

   localparam logic CMD_OFFER = 1'b0;
   localparam logic CMD_POP   = 1'b1;

   // Heap key: degree is the major part, vertex id the minor part.
   typedef struct packed {
      logic [31:0] degree;
      logic [31:0] vertex_id;
   } key_type;

   typedef struct packed {
      logic        command;
      logic [31:0] vertex_id;
      logic [31:0] degree;
   } req_type;

   typedef struct packed {
      logic [31:0] out_vertex;
      logic [31:0] out_degree;
      logic        heap_empty;
   } rsp_type;

endpackage

// ===== rtl/tkds_heap_ram.sv =====
// Heap storage: one write port, one read port with registered data.
// Depends on tkds_pkg for the key type.
module tkds_heap_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  tkds_pkg::key_type wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output tkds_pkg::key_type rd_data
);

   tkds_pkg::key_type mem [DEPTH];
   tkds_pkg::key_type rd_data_ff;

   // Write the addressed entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register read data; hold it while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tkds_key_cmp.sv =====
// Shared 64-bit key comparator of the sift sequencer.
// Depends on tkds_pkg for the key type.
module tkds_key_cmp (
   input  tkds_pkg::key_type lhs,
   input  tkds_pkg::key_type rhs,
   output logic              less
);

   logic [63:0] lhs_bits;
   logic [63:0] rhs_bits;

   // Compare as one unsigned word, degree above vertex id
   assign lhs_bits = lhs;
   assign rhs_bits = rhs;
   assign less     = (lhs_bits < rhs_bits);

endmodule

// ===== rtl/top_k_degree_selector_unit.sv =====
// Top-k degree selector: min-heap of the highest-degree vertices.
// req_stall stays high while an accepted request is worked on. An offer with hot_count zero is
// dropped without stalling, a refused offer costs one root compare, an insert climbs and a replace
// sifts down level by level; a pop on an empty heap only emits, else the last entry sifts down.
// The one RAM read port and the shared key comparator set the pace; a stalled result adds wait.
// Reset (synchronous, active high) empties the heap and sets hot_count to 16.
module top_k_degree_selector_unit #(
   parameter int CAPACITY = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  tkds_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output tkds_pkg::rsp_type            rsp_data,
   input  logic                         csr_write_enable,
   input  logic [tkds_pkg::HOT_W-1:0]   csr_write_data
);

`include "top_k_degree_selector_unit_assert.svh"

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = (CW > tkds_pkg::HOT_W) ? CW : tkds_pkg::HOT_W;
   localparam int IW = AW + 2;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_UP       = 4'd1;
   localparam logic [3:0] ST_UP_CMP   = 4'd2;
   localparam logic [3:0] ST_OFR_CMP  = 4'd3;
   localparam logic [3:0] ST_DOWN     = 4'd4;
   localparam logic [3:0] ST_DN_L     = 4'd5;
   localparam logic [3:0] ST_DN_R     = 4'd6;
   localparam logic [3:0] ST_DN_DEC   = 4'd7;
   localparam logic [3:0] ST_POP_TOP  = 4'd8;
   localparam logic [3:0] ST_POP_LAST = 4'd9;
   localparam logic [3:0] ST_EMIT     = 4'd10;

   logic [3:0]                state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [AW-1:0]             pos_ff, pos_in;
   logic [AW-1:0]             pick_ff, pick_in;
   tkds_pkg::key_type         item_ff, item_in;
   tkds_pkg::key_type         pick_key_ff, pick_key_in;
   logic                      pop_ff, pop_in;
   tkds_pkg::rsp_type         res_ff, res_in;
   logic [tkds_pkg::HOT_W-1:0] hot_count_ff;
   logic                      rsp_valid_ff;
   tkds_pkg::rsp_type         rsp_data_ff;

   logic                      ram_we;
   logic [AW-1:0]             ram_waddr;
   tkds_pkg::key_type         ram_wdata;
   logic                      ram_re;
   logic [AW-1:0]             ram_raddr;
   tkds_pkg::key_type         ram_rdata;
   tkds_pkg::key_type         cmp_lhs;
   tkds_pkg::key_type         cmp_rhs;
   logic                      cmp_less;

   logic [LW-1:0]             limit;
   logic [LW-1:0]             hot_ext;
   logic [AW-1:0]             parent;
   logic [IW-1:0]             left_ext;
   logic [IW-1:0]             right_ext;
   logic [IW-1:0]             n_ext;
   logic [CW-1:0]             count_m1;
   logic                      slot_free;
   logic [3:0]                done_state;

   logic                      pop_taken;
   logic                      emit_load;
   logic                      sifting;

   tkds_heap_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   tkds_key_cmp u_cmp (
      .lhs  (cmp_lhs),
      .rhs  (cmp_rhs),
      .less (cmp_less)
   );

   // Effective limit saturates at the heap capacity
   assign hot_ext = LW'(hot_count_ff);
   assign limit   = (hot_ext > LW'(CAPACITY)) ? LW'(CAPACITY) : hot_ext;

   // Heap index arithmetic
   assign parent     = (pos_ff - 1'b1) >> 1;
   assign left_ext   = IW'({pos_ff, 1'b1});
   assign right_ext  = left_ext + 1'b1;
   assign n_ext      = IW'(count_ff);
   assign count_m1   = count_ff - 1'b1;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign done_state = pop_ff ? ST_EMIT : ST_IDLE;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer: one RAM access and one key compare per cycle
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      pick_in     = pick_ff;
      item_in     = item_ff;
      pick_key_in = pick_key_ff;
      pop_in      = pop_ff;
      res_in      = res_ff;
      ram_we      = 1'b0;
      ram_waddr   = pos_ff;
      ram_wdata   = item_ff;
      ram_re      = 1'b0;
      ram_raddr   = '0;
      cmp_lhs     = item_ff;
      cmp_rhs     = ram_rdata;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.command == tkds_pkg::CMD_POP) begin
                  pop_in = 1'b1;
                  if (count_ff == '0) begin
                     res_in   = '{out_vertex: 32'd0, out_degree: 32'd0, heap_empty: 1'b1};
                     state_in = ST_EMIT;
                  end else begin
                     ram_re   = 1'b1;
                     state_in = ST_POP_TOP;
                  end
               end else begin
                  pop_in  = 1'b0;
                  item_in = '{degree: req_data.degree, vertex_id: req_data.vertex_id};
                  if (limit == '0) begin
                     state_in = ST_IDLE;
                  end else if (LW'(count_ff) < limit) begin
                     pos_in   = count_ff[AW-1:0];
                     count_in = count_ff + 1'b1;
                     state_in = ST_UP;
                  end else begin
                     ram_re   = 1'b1;
                     state_in = ST_OFR_CMP;
                  end
               end
            end
         end
         // Climb toward the root
         ST_UP: begin
            if (pos_ff == '0) begin
               ram_we   = 1'b1;
               state_in = done_state;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = parent;
               state_in  = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            cmp_lhs = item_ff;
            cmp_rhs = ram_rdata;
            ram_we  = 1'b1;
            if (!cmp_less) begin
               state_in = done_state;
            end else begin
               ram_wdata = ram_rdata;
               pos_in    = parent;
               state_in  = ST_UP;
            end
         end
         // Replace the root only on a strictly greater degree
         ST_OFR_CMP: begin
            cmp_lhs = '{degree: ram_rdata.degree, vertex_id: 32'hFFFF_FFFF};
            cmp_rhs = '{degree: item_ff.degree, vertex_id: 32'd0};
            if (cmp_less) begin
               pos_in   = '0;
               state_in = ST_DOWN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         // Descend: fetch left child or settle
         ST_DOWN: begin
            if (left_ext >= n_ext) begin
               ram_we   = 1'b1;
               state_in = done_state;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = left_ext[AW-1:0];
               state_in  = ST_DN_L;
            end
         end
         ST_DN_L: begin
            pick_key_in = ram_rdata;
            pick_in     = left_ext[AW-1:0];
            if (right_ext < n_ext) begin
               ram_re    = 1'b1;
               ram_raddr = right_ext[AW-1:0];
               state_in  = ST_DN_R;
            end else begin
               state_in = ST_DN_DEC;
            end
         end
         ST_DN_R: begin
            cmp_lhs = ram_rdata;
            cmp_rhs = pick_key_ff;
            if (cmp_less) begin
               pick_key_in = ram_rdata;
               pick_in     = right_ext[AW-1:0];
            end
            state_in = ST_DN_DEC;
         end
         ST_DN_DEC: begin
            cmp_lhs = pick_key_ff;
            cmp_rhs = item_ff;
            ram_we  = 1'b1;
            if (!cmp_less) begin
               state_in = done_state;
            end else begin
               ram_wdata = pick_key_ff;
               pos_in    = pick_ff;
               state_in  = ST_DOWN;
            end
         end
         // Take the root, move the last entry up
         ST_POP_TOP: begin
            res_in   = '{out_vertex: ram_rdata.vertex_id, out_degree: ram_rdata.degree,
                         heap_empty: 1'b0};
            count_in = count_m1;
            if (count_m1 != '0) begin
               ram_re    = 1'b1;
               ram_raddr = count_m1[AW-1:0];
               state_in  = ST_POP_LAST;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_POP_LAST: begin
            item_in  = ram_rdata;
            pos_in   = '0;
            state_in = ST_DOWN;
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pop_ff       <= 1'b0;
         hot_count_ff <= tkds_pkg::HOT_COUNT_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pop_ff   <= pop_in;
         if (csr_write_enable) begin
            hot_count_ff <= csr_write_data;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      pick_ff     <= pick_in;
      item_ff     <= item_in;
      pick_key_ff <= pick_key_in;
      res_ff      <= res_in;
   end

   // Output register: load on emit, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_EMIT && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && slot_free) begin
         rsp_data_ff <= res_ff;
      end
   end

   // Assertion terms
   assign pop_taken = req_valid && !req_stall && (req_data.command == tkds_pkg::CMD_POP);
   assign emit_load = (state_ff == ST_EMIT) && slot_free;
   assign sifting   = (state_ff == ST_DOWN) || (state_ff == ST_DN_DEC);

   `TKDS_ASSERT_NEXT(a_pop_starts, clock, reset, pop_taken, req_stall, "pop not started")
   `TKDS_ASSERT_NEXT(a_emit_valid, clock, reset, emit_load, rsp_valid_ff, "result not raised")
   `TKDS_ASSERT_NEXT(a_emit_data, clock, reset, emit_load, rsp_data_ff == res_ff, "bad result")
   `TKDS_ASSERT_IMPL(a_sift_nonempty, clock, reset, sifting, count_ff != '0, "sift on empty heap")

endmodule
